FILE: src/pm_pkg.sv
// ----------------------------------------------------------------------------
// pm_pkg: shared types and constants for the polynomial multiplier
// Coefficient, product and accumulator widths plus the per-cell control bundle.
// ----------------------------------------------------------------------------
package pm_pkg;

    localparam int COEFF_W = 32;  // Q16.16 input coefficient
    localparam int PROD_W  = 64;  // Q32.32 product / result
    localparam int ACC_W   = 70;  // exact sum of up to 32 products, plus headroom
    localparam int POWER_W = 5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic load_l;   // capture coeff as this cell's left term
        logic load_r;   // capture coeff as this cell's right term
        logic shift_r;  // take right term from upper neighbor
        logic active;   // left term is inside the loaded count
    } cell_ctrl_t;

endpackage

FILE: src/pm_cell.sv
// ----------------------------------------------------------------------------
// pm_cell: one tap of the transposed convolution chain
// Holds one left term and one right term; multiplies the broadcast right term
// by its left term and adds the product to the partial sum from above.
// ----------------------------------------------------------------------------
module pm_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pm_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [pm_pkg::COEFF_W-1:0]    coeff,
    input  logic signed [pm_pkg::COEFF_W-1:0]    x,
    input  logic signed [pm_pkg::COEFF_W-1:0]    r_in,
    output logic signed [pm_pkg::COEFF_W-1:0]    r_out,
    input  logic signed [pm_pkg::ACC_W-1:0]      acc_in,
    output logic signed [pm_pkg::ACC_W-1:0]      acc_out
);
    import pm_pkg::*;

    logic signed [COEFF_W-1:0] l_reg;
    logic signed [COEFF_W-1:0] r_reg;
    logic signed [COEFF_W-1:0] r_next;
    logic signed [PROD_W-1:0]  prod_full;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    always_comb
    begin
        if (ctrl.load_r)
            r_next = coeff;
        else if (ctrl.shift_r)
            r_next = r_in;
        else
            r_next = r_reg;
    end

    // full 32x32 signed product, sized by the 64-bit target
    assign prod_full = l_reg * x;

    // inactive cells contribute zero (left term beyond count)
    assign prod_next = ctrl.active ? prod_full : '0;
    assign acc_next  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} + acc_in;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_l)
            l_reg <= coeff;
        r_reg <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign r_out   = r_reg;
    assign acc_out = acc_reg;

endmodule

FILE: src/polynomial_multiply_core.sv
// ----------------------------------------------------------------------------
// polynomial_multiply_core: polynomial product by a chain of convolution cells
// Timing: a coefficient beat loads when start is taken while idle. After the right
//   operand's last beat, product terms appear in order of power, one term per cycle;
//   busy stays high for the whole run (multiplier then adder register per cell).
// Results are strobed by valid for one cycle each; the receiver cannot stall.
// Reset (async, active low) clears counts, flags, the accumulator chain and valid.
// ----------------------------------------------------------------------------
module polynomial_multiply_core #(
    parameter int MAX_TERMS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic signed [pm_pkg::COEFF_W-1:0]    coeff_in,
    input  logic                                 last_in,
    output logic                                 valid,
    output logic [pm_pkg::POWER_W-1:0]           power,
    output logic signed [pm_pkg::PROD_W-1:0]     coeff_out,
    output logic                                 last_out,
    output logic                                 saturated,
    output logic                                 truncated
);
    import pm_pkg::*;

    // count holds 0..MAX_TERMS; cycle counter runs to degL+degR+2 <= 2*MAX_TERMS
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int CYC_W = $clog2(2 * MAX_TERMS + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     lcnt_reg, lcnt_next;
    logic [CNT_W-1:0]     rcnt_reg, rcnt_next;
    logic                 ovf_reg, ovf_next;
    logic [CYC_W-1:0]     cyc_reg, cyc_next;

    logic                 valid_reg;
    logic [POWER_W-1:0]   power_reg;
    logic signed [PROD_W-1:0] coeff_reg;
    logic                 last_reg;
    logic                 sat_reg;
    logic                 trunc_reg;

    logic                 accept;
    logic                 ld_l, ld_r, trigger;
    logic                 running;
    logic [CYC_W-1:0]     degl, degr, n_last, k;
    logic [CYC_W+POWER_W-1:0] k_ext;
    logic                 emit, finish;
    logic signed [COEFF_W-1:0] x_bus;
    logic                 fits;
    logic signed [PROD_W-1:0] sat_val;

    cell_ctrl_t               ctrl [MAX_TERMS];
    logic signed [COEFF_W-1:0] r_w [MAX_TERMS+1];
    logic signed [ACC_W-1:0]   acc_w [MAX_TERMS+1];

    // ---------------- load path ----------------
    assign running = (state_reg == ST_RUN);
    assign accept  = start && !running;
    // a full store drops the beat and flags it
    assign ld_l    = accept && !req_type && (lcnt_reg != CNT_W'(MAX_TERMS));
    assign ld_r    = accept &&  req_type && (rcnt_reg != CNT_W'(MAX_TERMS));
    assign trigger = accept &&  req_type && last_in;

    // ---------------- product sequencing ----------------
    // empty operand behaves as the zero polynomial of degree 0
    assign degl   = (lcnt_reg == '0) ? '0 : CYC_W'(lcnt_reg) - CYC_W'(1);
    assign degr   = (rcnt_reg == '0) ? '0 : CYC_W'(rcnt_reg) - CYC_W'(1);
    assign n_last = degl + degr;
    // term k sits at the chain head once right term k's broadcast has passed cell 0's product and sum registers
    assign emit   = running && (cyc_reg >= CYC_W'(2));
    assign k      = cyc_reg - CYC_W'(2);
    assign finish = running && (cyc_reg == n_last + CYC_W'(2));
    assign k_ext  = {{POWER_W{1'b0}}, k};

    // right terms leave the chain head one per cycle; past the count, feed zero
    assign x_bus = (running && (cyc_reg < CYC_W'(rcnt_reg))) ? r_w[0] : '0;

    always_comb
    begin
        state_next = state_reg;
        lcnt_next  = lcnt_reg;
        rcnt_next  = rcnt_reg;
        ovf_next   = ovf_reg;
        cyc_next   = cyc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ld_l)
                    lcnt_next = lcnt_reg + CNT_W'(1);
                if (ld_r)
                    rcnt_next = rcnt_reg + CNT_W'(1);
                if (accept && !ld_l && !ld_r)
                    ovf_next = 1'b1;
                if (trigger)
                begin
                    state_next = ST_RUN;
                    cyc_next   = '0;
                end
            end
            ST_RUN:
            begin
                cyc_next = cyc_reg + CYC_W'(1);
                if (finish)
                begin
                    state_next = ST_IDLE;
                    lcnt_next  = '0;
                    rcnt_next  = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lcnt_reg  <= '0;
            rcnt_reg  <= '0;
            ovf_reg   <= 1'b0;
            cyc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lcnt_reg  <= lcnt_next;
            rcnt_reg  <= rcnt_next;
            ovf_reg   <= ovf_next;
            cyc_reg   <= cyc_next;
        end
    end

    // ---------------- cell chain ----------------
    // cell i keeps left term i and right term i; partial sums move toward cell 0
    assign r_w[MAX_TERMS]   = '0;
    assign acc_w[MAX_TERMS] = '0;

    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        assign ctrl[i].load_l  = ld_l && (lcnt_reg == CNT_W'(i));
        assign ctrl[i].load_r  = ld_r && (rcnt_reg == CNT_W'(i));
        assign ctrl[i].shift_r = running;
        assign ctrl[i].active  = (lcnt_reg > CNT_W'(i));

        pm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[i]),
            .coeff   (coeff_in),
            .x       (x_bus),
            .r_in    (r_w[i+1]),
            .r_out   (r_w[i]),
            .acc_in  (acc_w[i+1]),
            .acc_out (acc_w[i])
        );
    end

    // ---------------- saturation and output beat ----------------
    // exact sum fits 64 bits when all bits above bit 62 agree
    assign fits    = (&acc_w[0][ACC_W-1:PROD_W-1]) || !(|acc_w[0][ACC_W-1:PROD_W-1]);
    assign sat_val = acc_w[0][ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}}
                                       : {1'b0, {(PROD_W-1){1'b1}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            power_reg <= k_ext[POWER_W-1:0];
            coeff_reg <= fits ? acc_w[0][PROD_W-1:0] : sat_val;
            last_reg  <= finish;
            sat_reg   <= !fits;
            trunc_reg <= ovf_reg;
        end
    end

    assign busy      = running;
    assign valid     = valid_reg;
    assign power     = power_reg;
    assign coeff_out = coeff_reg;
    assign last_out  = last_reg;
    assign saturated = sat_reg;
    assign truncated = trunc_reg;

    // ---------------- assertions ----------------
    a_valid_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(running))
        else $error("result beat without a product run");

    a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last_out |=> valid)
        else $error("gap inside a result burst");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_out |=> !valid)
        else $error("beat after the last product term");

    a_trigger_runs: assert property (@(posedge clk) disable iff (!rst_n)
        trigger |=> running && (cyc_reg == '0))
        else $error("right last beat did not start a product");

    a_run_has_right: assert property (@(posedge clk) disable iff (!rst_n)
        running |-> (rcnt_reg != '0))
        else $error("product run with empty right store");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for polynomial_multiply_core
// Streams left/right coefficient beats into the core and predicts each product
// term with an exact convolution. Every strobed term is checked field by field,
// in order. Directed patterns come first, then three phases of random products.
// ----------------------------------------------------------------------------
module testbench;
    import pm_pkg::*;

    localparam int MAX_TERMS    = 16;
    localparam int CYCLE_CAP    = 200000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES = 8;       // quiet window after the last term
    localparam int PHASE_BEATS  = 70;      // random beats per idling phase
    localparam int MAX_PRINTS   = 40;

    // operand select on req_type
    localparam logic OP_LEFT  = 1'b0;
    localparam logic OP_RIGHT = 1'b1;

    localparam logic [COEFF_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [COEFF_W-1:0] Q_TWO = 32'h0002_0000;
    localparam logic [COEFF_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [COEFF_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [COEFF_W-1:0] Q_LSB = 32'h0000_0001;
    localparam logic [COEFF_W-1:0] Q_NEG = 32'hFFFF_FFFF;

    // exact accumulator bounds for the 64-bit clip
    localparam logic signed [71:0] ACC_TOP = 72'sh00_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [71:0] ACC_BOT = 72'shFF_8000_0000_0000_0000;

    // one product term as the core should strobe it
    typedef struct {
        logic [POWER_W-1:0]       power;
        logic signed [PROD_W-1:0] coeff;
        logic                     last;
        logic                     sat;
        logic                     trunc;
    } term_t;

    // one directed stimulus row; typed rows carry the single expected term
    typedef struct packed {
        logic               rtype;
        logic [COEFF_W-1:0] coeff;
        logic               last;
        logic [4:0]         reps;
        logic               typed;
        logic [PROD_W-1:0]  exp_coeff;
    } stim_row_t;

    localparam int N_ROWS = 16;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      start    = 1'b0;
    logic                      req_type = 1'b0;
    logic signed [COEFF_W-1:0] coeff_in = '0;
    logic                      last_in  = 1'b0;
    logic                      busy;
    logic                      valid;
    logic [POWER_W-1:0]        power;
    logic signed [PROD_W-1:0]  coeff_out;
    logic                      last_out;
    logic                      saturated;
    logic                      truncated;

    // predictor state: operand stores, counts, dropped-term flag
    logic signed [COEFF_W-1:0] left_store  [MAX_TERMS];
    logic signed [COEFF_W-1:0] right_store [MAX_TERMS];
    int unsigned               left_n;
    int unsigned               right_n;
    bit                        dropped;

    term_t       fresh_terms[$];   // terms caused by the latest beat
    term_t       product_q[$];     // terms still owed by the core
    term_t       want;
    int          errors = 0;
    int          idle_pct = 0;
    int unsigned cycles = 0;

    stim_row_t directed_rows [N_ROWS] = '{
        // 1.0 x 1.0 right after reset
        '{OP_LEFT,  Q_ONE, 1'b1, 5'd1,  1'b0, 64'h0},
        '{OP_RIGHT, Q_ONE, 1'b1, 5'd1,  1'b1, 64'h0000_0001_0000_0000},
        // no left terms: left acts as zero
        '{OP_RIGHT, Q_TWO, 1'b1, 5'd1,  1'b1, 64'h0},
        // min x min, max x min
        '{OP_LEFT,  Q_MIN, 1'b1, 5'd1,  1'b0, 64'h0},
        '{OP_RIGHT, Q_MIN, 1'b1, 5'd1,  1'b1, 64'h4000_0000_0000_0000},
        '{OP_LEFT,  Q_MAX, 1'b1, 5'd1,  1'b0, 64'h0},
        '{OP_RIGHT, Q_MIN, 1'b1, 5'd1,  1'b1, 64'hC000_0000_8000_0000},
        // two min^2 products in the middle term clip high; right beat w/o last
        '{OP_LEFT,  Q_MIN, 1'b0, 5'd2,  1'b0, 64'h0},
        '{OP_RIGHT, Q_MIN, 1'b0, 5'd1,  1'b0, 64'h0},
        '{OP_RIGHT, Q_MIN, 1'b1, 5'd1,  1'b0, 64'h0},
        // left last mark mid-operand, three min x max products clip low
        '{OP_LEFT,  Q_MIN, 1'b1, 5'd1,  1'b0, 64'h0},
        '{OP_LEFT,  Q_MIN, 1'b0, 5'd2,  1'b0, 64'h0},
        '{OP_RIGHT, Q_MAX, 1'b0, 5'd2,  1'b0, 64'h0},
        '{OP_RIGHT, Q_MAX, 1'b1, 5'd1,  1'b0, 64'h0},
        // one left term too many: dropped, every term flagged
        '{OP_LEFT,  Q_LSB, 1'b0, 5'd17, 1'b0, 64'h0},
        '{OP_RIGHT, Q_NEG, 1'b1, 5'd1,  1'b0, 64'h0}
    };

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    polynomial_multiply_core #(
        .MAX_TERMS (MAX_TERMS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .coeff_in  (coeff_in),
        .last_in   (last_in),
        .valid     (valid),
        .power     (power),
        .coeff_out (coeff_out),
        .last_out  (last_out),
        .saturated (saturated),
        .truncated (truncated)
    );

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    // Apply one accepted beat to the predictor. A right beat with last set
    // fires the convolution: one term per power 0 .. degL+degR, each an exact
    // sum of Q16.16 x Q16.16 products clipped to signed 64 bits.
    function automatic void convolve_beat(input logic rtype,
                                          input logic signed [COEFF_W-1:0] c,
                                          input logic lst);
        int unsigned deg_l;
        int unsigned deg_r;
        int unsigned k;
        int unsigned y;
        logic signed [71:0]       acc;
        logic signed [PROD_W-1:0] prod;
        term_t                    t;

        fresh_terms.delete();
        if (rtype == OP_LEFT) begin
            if (left_n < MAX_TERMS) begin
                left_store[left_n] = c;
                left_n++;
            end else
                dropped = 1'b1;
            return;
        end
        if (right_n < MAX_TERMS) begin
            right_store[right_n] = c;
            right_n++;
        end else
            dropped = 1'b1;
        if (!lst)
            return;

        // empty left operand is the zero polynomial of degree 0
        deg_l = (left_n != 0) ? left_n - 1 : 0;
        deg_r = right_n - 1;
        for (k = 0; k <= deg_l + deg_r; k++) begin
            acc = '0;
            for (y = 0; y <= deg_l; y++) begin
                if (y < left_n && y <= k && k - y <= deg_r) begin
                    prod = left_store[y] * right_store[k - y];
                    acc  = acc + prod;
                end
            end
            t.power = POWER_W'(k);
            t.last  = (k == deg_l + deg_r);
            t.trunc = dropped;
            t.sat   = (acc > ACC_TOP) || (acc < ACC_BOT);
            if (acc > ACC_TOP)
                t.coeff = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (acc < ACC_BOT)
                t.coeff = 64'sh8000_0000_0000_0000;
            else
                t.coeff = acc[PROD_W-1:0];
            fresh_terms.push_back(t);
        end
        left_n  = 0;
        right_n = 0;
        dropped = 1'b0;
    endfunction

    // Drive one beat, holding it until start meets a low busy at an edge.
    // A typed beat queues its hand-written term instead of the predicted one.
    task automatic send_beat(input logic rtype, input logic signed [COEFF_W-1:0] c,
                             input logic lst, input logic typed,
                             input logic signed [PROD_W-1:0] typed_coeff);
        term_t t;

        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rtype;
        coeff_in <= c;
        last_in  <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        convolve_beat(rtype, c, lst);
        if (typed) begin
            t.power = '0;
            t.coeff = typed_coeff;
            t.last  = 1'b1;
            t.sat   = 1'b0;
            t.trunc = 1'b0;
            product_q.push_back(t);
        end else begin
            foreach (fresh_terms[i])
                product_q.push_back(fresh_terms[i]);
        end
    endtask

    // Coefficient mix: extremes, full-range noise, small values near zero.
    // Hot products use only extremes so clipping shows up often.
    function automatic logic signed [COEFF_W-1:0] pick_coeff(input bit hot);
        int unsigned        sel;
        logic [COEFF_W-1:0] v;

        sel = hot ? $urandom_range(1) : $urandom_range(7);
        case (sel)
            0:       v = Q_MIN;
            1:       v = Q_MAX;
            2, 3:    v = $urandom;
            default: v = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        endcase
        return v;
    endfunction

    // Random products: random left/right term counts (now and then past the
    // limit), left and right beats interleaved, right last beat closes it.
    task automatic run_random(input int pct, input int beats);
        int unsigned n_l;
        int unsigned n_r;
        int          sent;
        bit          hot;
        bit          go_left;

        idle_pct = pct;
        sent = 0;
        while (sent < beats) begin
            n_l = ($urandom_range(7) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 8);
            n_r = ($urandom_range(7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 8);
            hot = ($urandom_range(5) == 0);
            while (n_l > 0 || n_r > 1) begin
                go_left = (n_r == 1) || (n_l > 0 && $urandom_range(1) == 1);
                if (go_left) begin
                    // stray last marks on left beats must be ignored
                    send_beat(OP_LEFT, pick_coeff(hot),
                              ($urandom_range(9) == 0) || (n_l == 1 && $urandom_range(1) == 1),
                              1'b0, '0);
                    n_l--;
                end else begin
                    send_beat(OP_RIGHT, pick_coeff(hot), 1'b0, 1'b0, '0);
                    n_r--;
                end
                sent++;
            end
            send_beat(OP_RIGHT, pick_coeff(hot), 1'b1, 1'b0, '0);
            sent++;
        end
    endtask

    // Result side: a strobed term is taken at the edge closing its cycle.
    always @(posedge clk) begin
        if (rst_n && valid) begin
            if (product_q.size() == 0)
                flag_mismatch($sformatf("unexpected term power=%0d coeff=%h",
                                        power, coeff_out));
            else begin
                want = product_q.pop_front();
                if (power !== want.power)
                    flag_mismatch($sformatf("power %0d, want %0d", power, want.power));
                if (coeff_out !== want.coeff)
                    flag_mismatch($sformatf("power %0d coeff %h, want %h",
                                            want.power, coeff_out, want.coeff));
                if (last_out !== want.last)
                    flag_mismatch($sformatf("power %0d last_out %b, want %b",
                                            want.power, last_out, want.last));
                if (saturated !== want.sat)
                    flag_mismatch($sformatf("power %0d saturated %b, want %b",
                                            want.power, saturated, want.sat));
                if (truncated !== want.trunc)
                    flag_mismatch($sformatf("power %0d truncated %b, want %b",
                                            want.power, truncated, want.trunc));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        left_n  = 0;
        right_n = 0;
        dropped = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed patterns, light sender idling
        idle_pct = 32;
        foreach (directed_rows[i]) begin
            repeat (directed_rows[i].reps)
                send_beat(directed_rows[i].rtype, directed_rows[i].coeff,
                          directed_rows[i].last, directed_rows[i].typed,
                          directed_rows[i].exp_coeff);
        end

        // random: light idling, heavy idling, back-to-back beats
        run_random(32, PHASE_BEATS);
        run_random(80, PHASE_BEATS);
        run_random(0, PHASE_BEATS);

        start <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
